// ===== src/nha_pkg.sv =====
// Shared constants, types and tables for the neighbour heading alignment block.
`timescale 1ns / 1ps
`default_nettype none

package nha_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 8;
  localparam int TIME_BITS     = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CMP_W         = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Field widths
  localparam int ID_W    = 4;
  localparam int ANGLE_W = 16;
  localparam int STEP_W  = 15;
  localparam int TTL_W   = 32;
  localparam int NOW_W   = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ANGLE_W-1:0]   angle_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    angle_t          angle;
    time_t           last_seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Input selector codes
  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_BCAST = 2'd1;
  localparam logic [1:0] FUNC_MOVE  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_TURN   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_OWN_ID     = 2'd0;
  localparam logic [1:0] REG_TTL        = 2'd1;
  localparam logic [1:0] REG_TURN_STEP  = 2'd2;
  localparam logic [1:0] REG_ALIGN_STEP = 2'd3;

  // Reset values
  localparam logic [ID_W-1:0]   OWN_ID_RST     = 4'd0;
  localparam logic [TTL_W-1:0]  TTL_RST        = 32'd30000;
  localparam logic [STEP_W-1:0] TURN_STEP_RST  = 15'd1267;
  localparam logic [STEP_W-1:0] ALIGN_STEP_RST = 15'd910;

  // Low nibble that marks an id frame
  localparam logic [3:0] ID_MARK = 4'hF;

  // Slice s (0..14) to binary angle, round(s * 65536 / 15)
  function automatic angle_t slice_angle(input logic [3:0] s);
    angle_t a;
    case (s)
      4'd0:    a = 16'd0;
      4'd1:    a = 16'd4369;
      4'd2:    a = 16'd8738;
      4'd3:    a = 16'd13107;
      4'd4:    a = 16'd17476;
      4'd5:    a = 16'd21845;
      4'd6:    a = 16'd26214;
      4'd7:    a = 16'd30583;
      4'd8:    a = 16'd34953;
      4'd9:    a = 16'd39322;
      4'd10:   a = 16'd43691;
      4'd11:   a = 16'd48060;
      4'd12:   a = 16'd52429;
      4'd13:   a = 16'd56798;
      4'd14:   a = 16'd61167;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== src/neighbour_heading_alignment.sv =====
// Top level: neighbour table, heading alignment and frame generation.
//
//  channel   | group        | payload
//  ----------+--------------+----------------------------------------------------
//  input     | in_t*        | tdata: now, msg_value, bearing; tuser: func, rx_error
//  result    | out_t*       | tdata: frame, turn_left, heading; tuser: kind; tlast
//  config    | cfg_*        | wr_en, addr (register index), wdata
//
// One item at a time. Status-only items go straight to the finish state;
// broadcast and motion items walk the entry RAM one entry per cycle while
// nothing stalls them; id frames walk it and write back the chosen slot.
// The single RAM read port sets the walk length.
// Reset clears the valid bits, heading and registers; entry RAM contents are
// only read behind a valid bit. A full output register stalls the walk of a
// broadcast; a new item is accepted while the last result still waits.
`timescale 1ns / 1ps
`default_nettype none

module neighbour_heading_alignment (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // now[31:0], msg_value[39:32], bearing[55:40]
  input  wire logic [2:0]  in_tuser,   // func[1:0], rx_error[2]
  // result transactions
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // frame[7:0], turn_left[8], heading[24:9], zero
  output logic      [1:0]  out_tuser,  // kind[1:0]
  output logic             out_tlast,
  // configuration writes
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_ADD_WR, S_FINISH} state_t;
  typedef enum logic [1:0] {OP_ADD, OP_BCAST, OP_MOVE} op_t;

  localparam nha_pkg::idx_t LAST_IDX = nha_pkg::idx_t'(nha_pkg::TABLE_ENTRIES - 1);

  // ---------------------------------------------------------------------------
  // Input field unpacking
  // ---------------------------------------------------------------------------
  logic [1:0]            in_func;
  logic                  in_err;
  logic [31:0]           in_now;
  logic [7:0]            in_msg;
  nha_pkg::angle_t       in_brg;
  logic [3:0]            msg_id;
  logic [3:0]            msg_low;

  assign in_func = in_tuser[1:0];
  assign in_err  = in_tuser[2];
  assign in_now  = in_tdata[31:0];
  assign in_msg  = in_tdata[39:32];
  assign in_brg  = in_tdata[55:40];
  assign msg_id  = in_msg[7:4];
  assign msg_low = in_msg[3:0];

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                          state_r, state_nxt;
  op_t                             op_r, op_nxt;
  nha_pkg::idx_t                   ev_idx_r, ev_idx_nxt;
  nha_pkg::angle_t                 heading_r, heading_nxt;
  logic [nha_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic [nha_pkg::ID_W-1:0]        own_id_r, own_id_nxt;
  logic [nha_pkg::TTL_W-1:0]       ttl_r, ttl_nxt;
  logic [nha_pkg::STEP_W-1:0]      turn_step_r, turn_step_nxt;
  logic [nha_pkg::STEP_W-1:0]      align_step_r, align_step_nxt;

  logic [nha_pkg::ID_W-1:0]        nid_r, nid_nxt;
  nha_pkg::angle_t                 brg_r, brg_nxt;
  nha_pkg::time_t                  now_r, now_nxt;
  nha_pkg::angle_t                 rot_r, rot_nxt;
  logic                            left_r, left_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [7:0]                      pend_r, pend_nxt;    // frame held back until next is known
  logic                            match_r, match_nxt;
  nha_pkg::idx_t                   match_idx_r, match_idx_nxt;
  nha_pkg::time_t                  best_age_r, best_age_nxt;
  nha_pkg::idx_t                   best_idx_r, best_idx_nxt;

  logic                            out_vld_r, out_vld_nxt;
  logic [1:0]                      out_kind_r, out_kind_nxt;
  logic [7:0]                      out_frame_r, out_frame_nxt;
  logic                            out_left_r, out_left_nxt;
  nha_pkg::angle_t                 out_head_r, out_head_nxt;
  logic                            out_last_r, out_last_nxt;

  // ---------------------------------------------------------------------------
  // Entry RAM
  // ---------------------------------------------------------------------------
  logic            ram_we;
  nha_pkg::idx_t   ram_waddr;
  nha_pkg::entry_t ram_wdata;
  nha_pkg::idx_t   ram_raddr;
  nha_pkg::entry_t ram_rdata;

  nha_ram #(
    .WIDTH (nha_pkg::ENTRY_W),
    .DEPTH (nha_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Per-entry evaluation of the word on the RAM read port
  // ---------------------------------------------------------------------------
  logic                     ev_valid;
  nha_pkg::time_t           ev_age;
  logic                     ev_live;
  nha_pkg::angle_t          rel_angle;
  logic [19:0]              rel_x15;
  logic [3:0]               ev_slice;

  always_comb begin
    ev_valid  = valid_r[ev_idx_r];
    ev_age    = now_r - ram_rdata.last_seen;
    ev_live   = ev_valid &&
                (nha_pkg::CMP_W'(ev_age) < nha_pkg::CMP_W'(ttl_r));
    rel_angle = heading_r - ram_rdata.angle;
    rel_x15   = {rel_angle, 4'b0000} - {4'b0000, rel_angle};
    ev_slice  = rel_x15[19:16];
  end

  // Highest free slot
  logic          free_found;
  nha_pkg::idx_t free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < nha_pkg::TABLE_ENTRIES; i++) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = nha_pkg::idx_t'(i);
      end
    end
  end

  // Alignment step on a slice frame addressed to this node
  nha_pkg::angle_t align_target;
  nha_pkg::angle_t align_delta;
  nha_pkg::angle_t align_heading;

  always_comb begin
    align_target = in_brg + 16'h8000 + nha_pkg::slice_angle(msg_low);
    align_delta  = align_target - heading_r;
    if (align_delta == '0) begin
      align_heading = heading_r;
    end else if (!align_delta[15]) begin
      align_heading = heading_r + {1'b0, align_step_r};
    end else begin
      align_heading = heading_r - {1'b0, align_step_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic            out_free;
  logic            stall;
  logic            push;
  logic [1:0]      push_kind;
  logic [7:0]      push_frame;
  logic            push_left;
  logic            push_last;
  logic            accept;
  logic            move_left;
  nha_pkg::angle_t move_rot;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign stall     = (state_r == S_WALK) && (op_r == OP_BCAST) && ev_live && !out_free;
  assign move_left = !heading_r[15];
  assign move_rot  = move_left ? (16'd0 - {1'b0, turn_step_r}) : {1'b0, turn_step_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ev_idx_nxt     = ev_idx_r;
    heading_nxt    = heading_r;
    valid_nxt      = valid_r;
    own_id_nxt     = own_id_r;
    ttl_nxt        = ttl_r;
    turn_step_nxt  = turn_step_r;
    align_step_nxt = align_step_r;
    nid_nxt        = nid_r;
    brg_nxt        = brg_r;
    now_nxt        = now_r;
    rot_nxt        = rot_r;
    left_nxt       = left_r;
    kind_nxt       = kind_r;
    pend_nxt       = pend_r;
    match_nxt      = match_r;
    match_idx_nxt  = match_idx_r;
    best_age_nxt   = best_age_r;
    best_idx_nxt   = best_idx_r;

    push       = 1'b0;
    push_kind  = kind_r;
    push_frame = pend_r;
    push_left  = left_r;
    push_last  = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = ev_idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = '0;

    // configuration writes: the user issues them only while idle; the block does not enforce it
    if (cfg_wr_en) begin
      case (cfg_addr)
        nha_pkg::REG_OWN_ID:     own_id_nxt     = cfg_wdata[nha_pkg::ID_W-1:0];
        nha_pkg::REG_TTL:        ttl_nxt        = cfg_wdata[nha_pkg::TTL_W-1:0];
        nha_pkg::REG_TURN_STEP:  turn_step_nxt  = cfg_wdata[nha_pkg::STEP_W-1:0];
        nha_pkg::REG_ALIGN_STEP: align_step_nxt = cfg_wdata[nha_pkg::STEP_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        // entry 0 is read now so the walk starts with data in hand
        ram_raddr = '0;
        if (accept) begin
          ev_idx_nxt = '0;
          left_nxt   = 1'b0;
          pend_nxt   = '0;
          kind_nxt   = nha_pkg::KIND_STATUS;
          state_nxt  = S_FINISH;
          case (in_func)
            nha_pkg::FUNC_BCAST: begin
              op_nxt    = OP_BCAST;
              now_nxt   = nha_pkg::time_t'(in_now);
              kind_nxt  = nha_pkg::KIND_FRAME;
              pend_nxt  = {own_id_r, nha_pkg::ID_MARK};
              state_nxt = S_WALK;
            end
            nha_pkg::FUNC_MOVE: begin
              op_nxt      = OP_MOVE;
              kind_nxt    = nha_pkg::KIND_TURN;
              left_nxt    = move_left;
              rot_nxt     = move_rot;
              heading_nxt = heading_r + move_rot;
              state_nxt   = S_WALK;
            end
            nha_pkg::FUNC_RX: begin
              if (!in_err) begin
                if (msg_low == nha_pkg::ID_MARK) begin
                  if (msg_id != own_id_r) begin
                    op_nxt       = OP_ADD;
                    nid_nxt      = msg_id;
                    brg_nxt      = in_brg;
                    now_nxt      = nha_pkg::time_t'(in_now);
                    match_nxt    = 1'b0;
                    match_idx_nxt = '0;
                    best_age_nxt = '0;
                    best_idx_nxt = '0;
                    state_nxt    = S_WALK;
                  end
                end else if (msg_id == own_id_r) begin
                  heading_nxt = align_heading;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        ram_raddr = stall ? ev_idx_r : ev_idx_r + 1'b1;
        case (op_r)
          OP_ADD: begin
            if (ev_valid && !match_r) begin
              if (ram_rdata.id == nid_r) begin
                match_nxt     = 1'b1;
                match_idx_nxt = ev_idx_r;
              end else if (ev_age > best_age_r) begin
                best_age_nxt = ev_age;
                best_idx_nxt = ev_idx_r;
              end
            end
          end
          OP_BCAST: begin
            if (ev_live && out_free) begin
              push       = 1'b1;
              push_frame = pend_r;
              push_last  = 1'b0;
              pend_nxt   = {ram_rdata.id, ev_slice};
            end
          end
          OP_MOVE: begin
            if (ev_valid) begin
              ram_we          = 1'b1;
              ram_waddr       = ev_idx_r;
              ram_wdata.angle = ram_rdata.angle + rot_r;
            end
          end
          default: ;
        endcase
        if (!stall) begin
          ev_idx_nxt = ev_idx_r + 1'b1;
          if (ev_idx_r == LAST_IDX) begin
            state_nxt = (op_r == OP_ADD) ? S_ADD_WR : S_FINISH;
          end
        end
      end

      S_ADD_WR: begin
        // refresh beats free slot beats oldest entry
        ram_we    = 1'b1;
        ram_waddr = match_r ? match_idx_r : (free_found ? free_idx : best_idx_r);
        ram_wdata.id        = nid_r;
        ram_wdata.angle     = brg_r;
        ram_wdata.last_seen = now_r;
        valid_nxt[ram_waddr] = 1'b1;
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // output register
    out_vld_nxt   = out_vld_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_frame_nxt = out_frame_r;
    out_left_nxt  = out_left_r;
    out_head_nxt  = out_head_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_vld_nxt   = 1'b1;
      out_kind_nxt  = push_kind;
      out_frame_nxt = push_frame;
      out_left_nxt  = push_left;
      out_head_nxt  = heading_r;
      out_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_ADD;
      ev_idx_r     <= '0;
      heading_r    <= '0;
      valid_r      <= '0;
      own_id_r     <= nha_pkg::OWN_ID_RST;
      ttl_r        <= nha_pkg::TTL_RST;
      turn_step_r  <= nha_pkg::TURN_STEP_RST;
      align_step_r <= nha_pkg::ALIGN_STEP_RST;
      match_r      <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      ev_idx_r     <= ev_idx_nxt;
      heading_r    <= heading_nxt;
      valid_r      <= valid_nxt;
      own_id_r     <= own_id_nxt;
      ttl_r        <= ttl_nxt;
      turn_step_r  <= turn_step_nxt;
      align_step_r <= align_step_nxt;
      match_r      <= match_nxt;
      out_vld_r    <= out_vld_nxt;
    end
    nid_r       <= nid_nxt;
    brg_r       <= brg_nxt;
    now_r       <= now_nxt;
    rot_r       <= rot_nxt;
    left_r      <= left_nxt;
    kind_r      <= kind_nxt;
    pend_r      <= pend_nxt;
    match_idx_r <= match_idx_nxt;
    best_age_r  <= best_age_nxt;
    best_idx_r  <= best_idx_nxt;
    out_kind_r  <= out_kind_nxt;
    out_frame_r <= out_frame_nxt;
    out_left_r  <= out_left_nxt;
    out_head_r  <= out_head_nxt;
    out_last_r  <= out_last_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result packing
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_head_r, out_left_r, out_frame_r};

endmodule

`default_nettype wire

// ===== src/nha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== dv/neighbour_heading_alignment_tb.sv =====
// Self-checking testbench for the neighbour heading alignment block.
`timescale 1ns / 1ps

module neighbour_heading_alignment_tb;

  // func code the block must treat as a plain status item
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 3 * (nha_pkg::TABLE_ENTRIES + 3);

  // one input transaction
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic [7:0]  msg;
    logic [15:0] bearing;
    logic        err;
  } rx_item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame;
    logic        turn_left;
    logic [15:0] heading;
    logic        last;
  } node_result_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata  = '0;   // now[31:0], msg_value[39:32], bearing[55:40]
  logic [2:0]  in_tuser  = '0;   // func[1:0], rx_error[2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // frame[7:0], turn_left[8], heading[24:9], zero
  logic [1:0]  out_tuser;        // kind[1:0]
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr  = '0;
  logic [31:0] cfg_wdata = '0;

  neighbour_heading_alignment dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predicted node state: neighbour table, heading and register copies
  // ---------------------------------------------------------------------------
  logic        nb_valid [nha_pkg::TABLE_ENTRIES] = '{default: 1'b0};
  logic [3:0]  nb_id    [nha_pkg::TABLE_ENTRIES] = '{default: '0};
  logic [15:0] nb_angle [nha_pkg::TABLE_ENTRIES] = '{default: '0};
  logic [31:0] nb_seen  [nha_pkg::TABLE_ENTRIES] = '{default: '0};
  logic [15:0] heading_q = '0;

  logic [3:0]  my_id     = nha_pkg::OWN_ID_RST;
  logic [31:0] ttl       = nha_pkg::TTL_RST;
  logic [14:0] turn_amt  = nha_pkg::TURN_STEP_RST;
  logic [14:0] align_amt = nha_pkg::ALIGN_STEP_RST;

  rx_item_t     pending_items [$];   // stimulus not yet offered
  node_result_t due_results   [$];   // results the block still owes
  int           fail_count = 0;
  logic [31:0]  clock_now  = 32'd5000;

  // Applies one accepted transaction to the predicted state and queues the
  // results it must produce, in order.
  function automatic void step_node(input rx_item_t it);
    node_result_t r;
    logic [31:0]  age;
    logic [31:0]  best_age;
    logic [31:0]  sang;
    logic [19:0]  scaled;
    logic [15:0]  rel;
    logic [15:0]  step;
    logic [15:0]  target;
    logic [15:0]  delta;
    logic [3:0]   nid;
    logic [3:0]   low;
    logic         left;
    logic         refreshed;
    int           free_slot;
    int           pick;
    r   = '0;
    nid = it.msg[7:4];
    low = it.msg[3:0];
    case (it.func)
      nha_pkg::FUNC_BCAST: begin
        // id frame first, then one slice frame per live neighbour
        r.kind    = nha_pkg::KIND_FRAME;
        r.heading = heading_q;
        r.frame   = {my_id, nha_pkg::ID_MARK};
        due_results.push_back(r);
        for (int i = 0; i < nha_pkg::TABLE_ENTRIES; i++) begin
          age = it.now - nb_seen[i];
          if (nb_valid[i] && age < ttl) begin
            rel     = heading_q - nb_angle[i];
            scaled  = {4'd0, rel} * 20'd15;
            r.frame = {nb_id[i], scaled[19:16]};
            due_results.push_back(r);
          end
        end
        r = due_results.pop_back();
        r.last = 1'b1;
        due_results.push_back(r);
      end
      nha_pkg::FUNC_MOVE: begin
        // non-negative heading turns left: everything rotates by -turn_step
        left = ~heading_q[15];
        step = left ? 16'd0 - {1'b0, turn_amt} : {1'b0, turn_amt};
        heading_q = heading_q + step;
        for (int i = 0; i < nha_pkg::TABLE_ENTRIES; i++)
          if (nb_valid[i]) nb_angle[i] = nb_angle[i] + step;
        r.kind      = nha_pkg::KIND_TURN;
        r.turn_left = left;
        r.heading   = heading_q;
        r.last      = 1'b1;
        due_results.push_back(r);
      end
      default: begin
        if (it.func == nha_pkg::FUNC_RX && !it.err) begin
          if (low == nha_pkg::ID_MARK) begin
            if (nid != my_id) begin
              // refresh a known id, else last free slot, else oldest entry
              refreshed = 1'b0;
              free_slot = -1;
              pick      = 0;
              best_age  = '0;
              for (int i = 0; i < nha_pkg::TABLE_ENTRIES; i++) begin
                if (nb_valid[i]) begin
                  age = it.now - nb_seen[i];
                  if (!refreshed && nb_id[i] == nid) begin
                    nb_angle[i] = it.bearing;
                    nb_seen[i]  = it.now;
                    refreshed   = 1'b1;
                  end else if (age > best_age) begin
                    best_age = age;
                    pick     = i;
                  end
                end else begin
                  free_slot = i;
                end
              end
              if (!refreshed) begin
                if (free_slot >= 0) pick = free_slot;
                nb_valid[pick] = 1'b1;
                nb_id[pick]    = nid;
                nb_angle[pick] = it.bearing;
                nb_seen[pick]  = it.now;
              end
            end
          end else if (nid == my_id) begin
            // slice addressed to us: step heading toward the decoded angle
            sang   = ({28'd0, low} * 32'd65536 + 32'd7) / 32'd15;
            target = it.bearing - 16'h8000 + sang[15:0];
            delta  = target - heading_q;
            if (delta != 16'd0)
              heading_q = delta[15] ? heading_q - {1'b0, align_amt}
                                    : heading_q + {1'b0, align_amt};
          end
        end
        r.kind    = nha_pkg::KIND_STATUS;
        r.heading = heading_q;
        r.last    = 1'b1;
        due_results.push_back(r);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps, fed from pending_items
  // ---------------------------------------------------------------------------
  rx_item_t cur_item   = '0;
  logic     holding    = 1'b0;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // predict at the edge where the transaction is taken
      if (in_tvalid && in_tready) begin
        step_node(cur_item);
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding  = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_tvalid <= holding;
      in_tdata  <= {cur_item.bearing, cur_item.msg, cur_item.now};
      in_tuser  <= {cur_item.err, cur_item.func};
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stalls in stretches of varying density, checks results
  // ---------------------------------------------------------------------------
  node_result_t want;
  int           stall_run = 0;
  int           stall_pct = 0;

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with nothing outstanding: kind %0d tdata 0x%0h",
               out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("kind",      32'(want.kind),      32'(out_tuser));
        check_field("frame",     32'(want.frame),     32'(out_tdata[7:0]));
        check_field("turn_left", 32'(want.turn_left), 32'(out_tdata[8]));
        check_field("heading",   32'(want.heading),   32'(out_tdata[24:9]));
        check_field("last",      32'(want.last),      32'(out_tlast));
      end
    end
    if (stall_run == 0) begin
      stall_run = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_run--;
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: abandon the run if both channels sit quiet too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] func, input logic [31:0] now,
                            input logic [7:0] msg, input logic [15:0] bearing,
                            input logic err);
    rx_item_t it;
    it = '{func: func, now: now, msg: msg, bearing: bearing, err: err};
    pending_items.push_back(it);
  endtask

  // Block until everything offered is taken and answered, then let any
  // walk still in flight finish before touching registers.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || holding || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Upper bits beyond the id and step registers' widths carry junk; the block must drop it.
  task automatic set_regs(input logic [3:0] id, input logic [31:0] ttl_v,
                          input logic [14:0] turn_v, input logic [14:0] align_v);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(nha_pkg::REG_OWN_ID, {junk[31:4], id});
    write_reg(nha_pkg::REG_TTL, ttl_v);
    junk = $urandom;
    write_reg(nha_pkg::REG_TURN_STEP, {junk[31:15], turn_v});
    junk = $urandom;
    write_reg(nha_pkg::REG_ALIGN_STEP, {junk[31:15], align_v});
    my_id     = id;
    ttl       = ttl_v;
    turn_amt  = turn_v;
    align_amt = align_v;
  endtask

  // Mix weighted toward id frames and addressed slices so the table fills,
  // evicts and ages, with broadcasts and moves interleaved to observe it.
  task automatic queue_random_items(input int count, input int stride);
    rx_item_t   it;
    int         pick;
    logic [3:0] s;
    repeat (count) begin
      pick       = $urandom_range(0, 99);
      it.func    = nha_pkg::FUNC_RX;
      it.msg     = 8'($urandom);
      it.bearing = 16'($urandom);
      it.err     = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 15) == 0)
        clock_now = $urandom;                 // jump, may land behind entries
      else
        clock_now = clock_now + $urandom_range(0, stride);
      it.now = clock_now;
      if (pick < 35) begin
        it.msg[3:0] = nha_pkg::ID_MARK;
      end else if (pick < 55) begin
        s      = 4'($urandom_range(0, 14));
        it.msg = {my_id, s};
      end else if (pick < 62) begin
        // arbitrary byte: mostly foreign slices
      end else if (pick < 80) begin
        it.func = nha_pkg::FUNC_BCAST;
      end else if (pick < 95) begin
        it.func = nha_pkg::FUNC_MOVE;
      end else begin
        it.func = FUNC_UNUSED;
      end
      pending_items.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] ttl_v;
    int          stride;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, registers at reset values (own id 0)
    queue_item(nha_pkg::FUNC_BCAST, 32'd0,         8'h00, 16'h0000, 1'b0); // empty table
    queue_item(nha_pkg::FUNC_RX,    32'd50,        8'h0F, 16'h7FFF, 1'b0); // own id frame
    queue_item(nha_pkg::FUNC_RX,    32'd100,       8'h1F, 16'h7FFF, 1'b0); // add id 1
    queue_item(nha_pkg::FUNC_RX,    32'd200,       8'h2F, 16'h8000, 1'b0); // add id 2
    queue_item(nha_pkg::FUNC_RX,    32'd300,       8'h1F, 16'h0000, 1'b0); // refresh id 1
    queue_item(nha_pkg::FUNC_RX,    32'd310,       8'h3F, 16'h1234, 1'b1); // rx error
    queue_item(FUNC_UNUSED,         32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1); // unknown func
    queue_item(nha_pkg::FUNC_RX,    32'd400,       8'h00, 16'h0000, 1'b0); // slice 0, -pi
    queue_item(nha_pkg::FUNC_RX,    32'd410,       8'h0E, 16'h7FFF, 1'b0); // slice 14
    queue_item(nha_pkg::FUNC_RX,    32'd420,       8'h5A, 16'h4000, 1'b0); // other node
    queue_item(nha_pkg::FUNC_MOVE,  32'd430,       8'h00, 16'h0000, 1'b0); // negative: right
    queue_item(nha_pkg::FUNC_BCAST, 32'd500,       8'h00, 16'h0000, 1'b0);
    queue_item(nha_pkg::FUNC_MOVE,  32'd510,       8'h00, 16'h0000, 1'b0);
    queue_item(nha_pkg::FUNC_MOVE,  32'd520,       8'h00, 16'h0000, 1'b0); // left
    queue_item(nha_pkg::FUNC_BCAST, 32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b0); // all stale
    wait_idle();

    // Alignment on an exact hit, then on a target exactly opposite
    queue_item(nha_pkg::FUNC_RX, 32'd600, {my_id, 4'd0}, heading_q + 16'h8000, 1'b0);
    queue_item(nha_pkg::FUNC_RX, 32'd610, {my_id, 4'd0}, heading_q, 1'b0);
    // Fill the table at one time stamp: all ages tie at zero, so entry 0 goes
    queue_item(nha_pkg::FUNC_RX, 32'd1000, 8'h1F, 16'h0100, 1'b0);
    queue_item(nha_pkg::FUNC_RX, 32'd1000, 8'h2F, 16'h0200, 1'b0);
    for (int id = 4; id < 10; id++)
      queue_item(nha_pkg::FUNC_RX, 32'd1000, {id[3:0], nha_pkg::ID_MARK},
                 16'(id * 4096), 1'b0);
    queue_item(nha_pkg::FUNC_RX, 32'd1000, 8'hAF, 16'hC000, 1'b0);
    // Equal ages again, lowest index wins
    queue_item(nha_pkg::FUNC_RX, 32'd2000, 8'hBF, 16'hE000, 1'b0);
    queue_item(nha_pkg::FUNC_BCAST, 32'd2000, 8'h00, 16'h0000, 1'b0);
    wait_idle();

    // Random phases, each behind its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_regs(4'hF, 32'd0, 15'd0, 15'h7FFF);
        1:       set_regs(4'h0, 32'hFFFF_FFFF, 15'h7FFF, 15'd0);
        2:       set_regs(4'h1, 32'd1, 15'd1, 15'd1);
        default: begin
          ttl_v = $urandom_range(100, 6000);
          set_regs(4'($urandom), ttl_v, 15'($urandom), 15'($urandom));
        end
      endcase
      stride = (ttl > 32'd100000) ? 2000 : int'(ttl / 3) + 1;
      queue_random_items(44, stride);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
src/nha_pkg.sv
src/nha_ram.sv
src/neighbour_heading_alignment.sv
dv/neighbour_heading_alignment_tb.sv
